/* rtl/aip_pkg.sv */
// Shared types, constants and character decode functions for the ASCII integer parser.
package aip_pkg;

   localparam int AIP_VALUE_WIDTH = 64;
   localparam int AIP_ADDR_WIDTH  = 3;
   localparam int AIP_DATA_WIDTH  = 32;

   // register indexes
   localparam logic [0:0] REG_SIGNED_MODE = 1'b0;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_UPX   = 8'h58;
   localparam logic [7:0] CHAR_LOWX  = 8'h78;
   localparam logic [7:0] CHAR_UPA   = 8'h41;
   localparam logic [7:0] CHAR_UPF   = 8'h46;
   localparam logic [7:0] CHAR_LOWA  = 8'h61;
   localparam logic [7:0] CHAR_LOWF  = 8'h66;

   typedef enum logic [6:0] {
      PH_START = 7'b0000001,
      PH_SIGN  = 7'b0000010,
      PH_ZERO  = 7'b0000100,
      PH_DEC   = 7'b0001000,
      PH_HEX   = 7'b0010000,
      PH_ERR   = 7'b0100000,
      PH_ENDED = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type dec_digit(input logic [7:0] c);
      digit_type d;
      d.ok    = 1'b0;
      d.value = 4'd0;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         d.ok    = 1'b1;
         d.value = 4'(c - CHAR_ZERO);
      end
      return d;
   endfunction

   function automatic digit_type hex_digit(input logic [7:0] c);
      digit_type d;
      d.ok    = 1'b0;
      d.value = 4'd0;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         d.ok    = 1'b1;
         d.value = 4'(c - CHAR_ZERO);
      end else if (c inside {[CHAR_LOWA:CHAR_LOWF]}) begin
         d.ok    = 1'b1;
         d.value = 4'(c - CHAR_LOWA + 8'd10);
      end else if (c inside {[CHAR_UPA:CHAR_UPF]}) begin
         d.ok    = 1'b1;
         d.value = 4'(c - CHAR_UPA + 8'd10);
      end
      return d;
   endfunction

endpackage

/* rtl/aip_csr.sv */
// Configuration register block: holds signed_mode behind an APB-style port.
module aip_csr
   import aip_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [AIP_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [AIP_DATA_WIDTH-1:0] csr_pwdata,
   output logic [AIP_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output logic                      signed_mode
);

   logic       signed_mode_ff;
   logic       signed_mode_in;
   logic [0:0] reg_index;
   logic       wr_en;

   assign reg_index = csr_paddr[AIP_ADDR_WIDTH-1 -: 1];
   assign wr_en     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      signed_mode_in = signed_mode_ff;
      if (wr_en && (reg_index == REG_SIGNED_MODE)) begin
         signed_mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b0;
      end else begin
         signed_mode_ff <= signed_mode_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_index)
         REG_SIGNED_MODE: csr_prdata = {{(AIP_DATA_WIDTH-1){1'b0}}, signed_mode_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready  = 1'b1;
   assign signed_mode = signed_mode_ff;

endmodule

/* rtl/aip_parse.sv */
// Parse datapath: input beat register, token state update, result register.
module aip_parse
   import aip_pkg::*;
#(
   parameter int VALUE_WIDTH = AIP_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   signed_mode,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_char_byte,
   input  logic                   req_terminator,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_parsed_value,
   output logic                   rsp_parse_error
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_term_ff;

   // token state
   phase_type              phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   neg_ff, neg_in;

   // result register
   logic                   out_vld_ff, out_vld_in;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic                   out_error_ff;

   logic                   out_free;
   logic                   consume;
   logic                   take;
   logic                   load_out;
   logic                   res_err;
   logic [VALUE_WIDTH-1:0] res_value;
   logic [VALUE_WIDTH-1:0] acc_x10;
   logic [VALUE_WIDTH-1:0] acc_x16;
   digit_type              dd;
   digit_type              hd;
   logic                   is_sign;

   assign out_free  = !out_vld_ff || !rsp_stall;
   // a byte beat never waits; a terminator waits for room in the result register
   assign consume   = in_vld_ff && (!in_term_ff || out_free);
   assign req_stall = in_vld_ff && !consume;
   assign take      = req_valid && !req_stall;
   assign load_out  = consume && in_term_ff;

   assign in_vld_in  = take || (in_vld_ff && !consume);
   assign out_vld_in = load_out || (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= PH_START;
         acc_ff     <= '0;
         neg_ff     <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_char_byte;
         in_term_ff <= req_terminator;
      end
      if (load_out) begin
         out_value_ff <= res_value;
         out_error_ff <= res_err;
      end
   end

   // x10 as two shifted adds, x16 as a shift
   assign acc_x10 = {acc_ff[VALUE_WIDTH-4:0], 3'b000} + {acc_ff[VALUE_WIDTH-2:0], 1'b0}
                    + VALUE_WIDTH'(dd.value);
   assign acc_x16 = {acc_ff[VALUE_WIDTH-5:0], hd.value};
   assign dd      = dec_digit(in_byte_ff);
   assign hd      = hex_digit(in_byte_ff);
   assign is_sign = (in_byte_ff == CHAR_PLUS) || (in_byte_ff == CHAR_MINUS);

   always_comb begin
      res_err   = (phase_ff == PH_START) || (phase_ff == PH_SIGN) || (phase_ff == PH_ERR);
      res_value = '0;
      if (!res_err) begin
         res_value = neg_ff ? (~acc_ff + VALUE_WIDTH'(1)) : acc_ff;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      if (consume) begin
         if (in_term_ff) begin
            phase_in = PH_START;
            acc_in   = '0;
            neg_in   = 1'b0;
         end else if ((phase_ff == PH_ERR) || (phase_ff == PH_ENDED)) begin
            phase_in = phase_ff;
         end else if (in_byte_ff == CHAR_NUL) begin
            phase_in = ((phase_ff == PH_START) || (phase_ff == PH_SIGN)) ? PH_ERR : PH_ENDED;
         end else begin
            case (phase_ff)
               PH_START, PH_SIGN: begin
                  if ((phase_ff == PH_START) && signed_mode && is_sign) begin
                     neg_in   = (in_byte_ff == CHAR_MINUS);
                     phase_in = PH_SIGN;
                  end else if (in_byte_ff == CHAR_ZERO) begin
                     acc_in   = '0;
                     phase_in = PH_ZERO;
                  end else if (dd.ok) begin
                     acc_in   = VALUE_WIDTH'(dd.value);
                     phase_in = PH_DEC;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_ZERO, PH_DEC: begin
                  if ((phase_ff == PH_ZERO) &&
                      ((in_byte_ff == CHAR_LOWX) || (in_byte_ff == CHAR_UPX))) begin
                     acc_in   = '0;
                     phase_in = PH_HEX;
                  end else if (dd.ok) begin
                     acc_in   = acc_x10;
                     phase_in = PH_DEC;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               PH_HEX: begin
                  if (hd.ok) begin
                     acc_in = acc_x16;
                  end else begin
                     phase_in = PH_ERR;
                  end
               end
               default: begin
                  phase_in = PH_ERR;
               end
            endcase
         end
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_parsed_value = out_value_ff;
   assign rsp_parse_error  = out_error_ff;

endmodule

/* rtl/ascii_integer_parser_unit.sv */
// Top level of the ASCII decimal/hex integer parser.
// One beat is taken every cycle unless req_stall is high. Each beat lands in an
// input register; a byte beat updates the token state in the next cycle (one x10
// shift-add or x16 shift per byte). A terminator beat loads the result register,
// which drives rsp_valid. A byte in the input register never waits. A terminator
// waits there while the result register holds an untaken result, and the input
// stalls until the terminator moves on.
// signed_mode is read at the start of each token; write it while the unit is idle.
module ascii_integer_parser_unit
   import aip_pkg::*;
#(
   parameter int VALUE_WIDTH = AIP_VALUE_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_char_byte,
   input  logic                      req_terminator,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [VALUE_WIDTH-1:0]    rsp_parsed_value,
   output logic                      rsp_parse_error,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [AIP_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [AIP_DATA_WIDTH-1:0] csr_pwdata,
   output logic [AIP_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic signed_mode;

   aip_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .signed_mode (signed_mode)
   );

   aip_parse #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_parse (
      .clock            (clock),
      .reset            (reset),
      .signed_mode      (signed_mode),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_terminator   (req_terminator),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_parse_error  (rsp_parse_error)
   );

endmodule

/* tb/aip_result_checker.sv */
// Watches the parser's channels and CSR port, predicts each parse and compares results.
module aip_result_checker
   import aip_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [7:0]                 req_char_byte,
   input  logic                       req_terminator,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [AIP_VALUE_WIDTH-1:0] rsp_parsed_value,
   input  logic                       rsp_parse_error,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [AIP_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [AIP_DATA_WIDTH-1:0]  csr_pwdata,
   input  logic [AIP_DATA_WIDTH-1:0]  csr_prdata,
   input  logic                       csr_pready,
   output int                         mismatch_count,
   output int                         pending_results,
   output int                         results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [AIP_VALUE_WIDTH-1:0] value;
      logic                       error;
   } parse_result_type;

   parse_result_type expected_q[$];

   logic                       mode_signed;
   phase_type                  tok_phase;
   logic [AIP_VALUE_WIDTH-1:0] tok_acc;
   logic                       tok_neg;

   function automatic int decimal_weight(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      return -1;
   endfunction

   function automatic int hex_weight(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_LOWA && c <= CHAR_LOWF) return int'(c - CHAR_LOWA) + 10;
      if (c >= CHAR_UPA && c <= CHAR_UPF) return int'(c - CHAR_UPA) + 10;
      return -1;
   endfunction

   function automatic void clear_token();
      tok_phase = PH_START;
      tok_acc   = '0;
      tok_neg   = 1'b0;
   endfunction

   // one byte beat of the current token
   function automatic void advance_token(input logic [7:0] c);
      int d;
      if (tok_phase == PH_ERR || tok_phase == PH_ENDED) return;
      if (c == CHAR_NUL) begin
         // NUL ends the parse; no digit seen yet means an empty token
         if (tok_phase == PH_START || tok_phase == PH_SIGN) tok_phase = PH_ERR;
         else tok_phase = PH_ENDED;
         return;
      end
      case (tok_phase)
         PH_START, PH_SIGN: begin
            if (tok_phase == PH_START && mode_signed && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
               tok_neg   = (c == CHAR_MINUS);
               tok_phase = PH_SIGN;
            end else begin
               d = decimal_weight(c);
               if (d < 0) begin
                  tok_phase = PH_ERR;
               end else begin
                  tok_acc   = AIP_VALUE_WIDTH'(d);
                  tok_phase = (c == CHAR_ZERO) ? PH_ZERO : PH_DEC;
               end
            end
         end
         PH_ZERO, PH_DEC: begin
            if (tok_phase == PH_ZERO && (c == CHAR_LOWX || c == CHAR_UPX)) begin
               tok_acc   = '0;
               tok_phase = PH_HEX;
            end else begin
               d = decimal_weight(c);
               if (d < 0) begin
                  tok_phase = PH_ERR;
               end else begin
                  tok_acc   = tok_acc * AIP_VALUE_WIDTH'(10) + AIP_VALUE_WIDTH'(d);
                  tok_phase = PH_DEC;
               end
            end
         end
         PH_HEX: begin
            d = hex_weight(c);
            if (d < 0) tok_phase = PH_ERR;
            else tok_acc = (tok_acc << 4) + AIP_VALUE_WIDTH'(d);
         end
         default: tok_phase = PH_ERR;
      endcase
   endfunction

   function automatic parse_result_type finish_token();
      parse_result_type r;
      r.error = (tok_phase == PH_START || tok_phase == PH_SIGN || tok_phase == PH_ERR);
      if (r.error) r.value = '0;
      else if (tok_neg) r.value = ~tok_acc + AIP_VALUE_WIDTH'(1);
      else r.value = tok_acc;
      clear_token();
      return r;
   endfunction

   always @(posedge clock) begin
      parse_result_type got, want;
      if (reset) begin
         mode_signed = 1'b0;
         clear_token();
         expected_q.delete();
         mismatch_count  = 0;
         results_checked = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             int'(csr_paddr >> 2) == int'(REG_SIGNED_MODE)) begin
            if (csr_pwrite) begin
               mode_signed = csr_pwdata[0];
            end else if (csr_prdata !== AIP_DATA_WIDTH'(mode_signed)) begin
               $display("%0t: signed_mode readback mismatch, expected %h, actual %h",
                        $time, AIP_DATA_WIDTH'(mode_signed), csr_prdata);
               mismatch_count++;
            end
         end
         if (req_valid && !req_stall) begin
            if (req_terminator) expected_q.insert(expected_q.size(), finish_token());
            else advance_token(req_char_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            got.value = rsp_parsed_value;
            got.error = rsp_parse_error;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %h error %b",
                        $time, got.value, got.error);
               mismatch_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.value !== want.value) begin
                  $display("%0t: parsed_value mismatch, expected %h, actual %h",
                           $time, want.value, got.value);
                  mismatch_count++;
               end
               if (got.error !== want.error) begin
                  $display("%0t: parse_error mismatch, expected %b, actual %b",
                           $time, want.error, got.error);
                  mismatch_count++;
               end
               results_checked++;
            end
         end
      end
      pending_results = expected_q.size();
   end

endmodule

/* tb/tb_top.sv */
// Stimulus, flow control and verdict for the ASCII integer parser.
module tb_top
   import aip_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIGNED_MODE_ADDR = 4 * int'(REG_SIGNED_MODE);
   localparam int REG_UNUSED       = 1;
   localparam int UNUSED_ADDR      = 4 * REG_UNUSED;
   localparam int RUN_LIMIT        = 200000;
   localparam int HOLD_CYCLES      = 400;
   localparam int BEATS_PER_PHASE  = 165;
   localparam int SETTLE_CYCLES    = 8;

   typedef logic [7:0] char_q_type[$];

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_char_byte = 8'h00;
   logic                       req_terminator = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [AIP_VALUE_WIDTH-1:0] rsp_parsed_value;
   logic                       rsp_parse_error;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [AIP_ADDR_WIDTH-1:0]  csr_paddr = '0;
   logic [AIP_DATA_WIDTH-1:0]  csr_pwdata = '0;
   logic [AIP_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   int mismatch_count;
   int pending_results;
   int results_checked;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_armed    = 1'b0;
   bit hold_done     = 1'b0;
   int beats_sent    = 0;
   int tokens_sent   = 0;

   always #5 clock = ~clock;

   ascii_integer_parser_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_terminator   (req_terminator),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_parse_error  (rsp_parse_error),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   aip_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_terminator   (req_terminator),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_parse_error  (rsp_parse_error),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results),
      .results_checked  (results_checked)
   );

   // result side: random stall, plus one long hold-off that lets the unit back up
   initial begin : result_sink
      int n;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            for (n = 0; n < HOLD_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            hold_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin : watchdog
      repeat (RUN_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still pending", RUN_LIMIT, pending_results);
      $display("FAILED: results differ");
      $finish;
   end

   task automatic csr_access(input bit write, input int addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= AIP_ADDR_WIDTH'(addr);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write signed_mode with junk in the unused bits, then read it back
   task automatic set_signed_mode(input bit mode);
      csr_access(1'b1, SIGNED_MODE_ADDR, ($urandom & ~32'h1) | 32'(mode));
      csr_access(1'b0, SIGNED_MODE_ADDR, $urandom);
   endtask

   task automatic send_beat(input logic [7:0] c, input bit term);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid     <= 1'b0;
         req_char_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_char_byte  <= c;
      req_terminator <= term;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic send_token(input char_q_type t);
      foreach (t[i]) send_beat(t[i], 1'b0);
      // byte on a terminator beat is don't-care
      send_beat(8'($urandom), 1'b1);
      tokens_sent++;
   endtask

   // drop valid, wait for every result, then let in-flight bytes settle
   task automatic wait_quiet(input int settle);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (settle) @(posedge clock);
   endtask

   function automatic char_q_type text_chars(input string s);
      char_q_type t;
      for (int i = 0; i < s.len(); i++) t.insert(t.size(), s[i]);
      return t;
   endfunction

   function automatic logic [7:0] rand_hex_char();
      int v;
      v = $urandom_range(21);
      if (v < 10) return 8'(CHAR_ZERO + v);
      if (v < 16) return 8'(CHAR_LOWA + v - 10);
      return 8'(CHAR_UPA + v - 16);
   endfunction

   function automatic char_q_type make_token();
      char_q_type t;
      int kind, n, r;
      bit long_run;
      kind = $urandom_range(99);
      long_run = ($urandom_range(7) == 0);
      if (kind < 8) begin
         n = $urandom_range(1, 6);
         repeat (n) t.insert(t.size(), 8'($urandom));
         return t;
      end
      if (kind < 11) return t;
      if ($urandom_range(3) == 0) t.insert(t.size(), $urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
      if (kind < 50) begin
         n = long_run ? $urandom_range(18, 24) : $urandom_range(1, 6);
         repeat (n) t.insert(t.size(), 8'(CHAR_ZERO + $urandom_range(9)));
      end else if (kind < 85) begin
         t.insert(t.size(), CHAR_ZERO);
         t.insert(t.size(), $urandom_range(1) ? CHAR_LOWX : CHAR_UPX);
         n = long_run ? $urandom_range(15, 20) : $urandom_range(0, 6);
         repeat (n) t.insert(t.size(), rand_hex_char());
      end else if (kind < 93) begin
         // leading zeros in a decimal token
         repeat ($urandom_range(1, 3)) t.insert(t.size(), CHAR_ZERO);
         repeat ($urandom_range(0, 4)) t.insert(t.size(), 8'(CHAR_ZERO + $urandom_range(9)));
      end
      r = $urandom_range(99);
      if (r < 12) begin
         t.insert($urandom_range(t.size()), 8'($urandom));
      end else if (r < 22) begin
         t.insert(t.size(), CHAR_NUL);
         repeat ($urandom_range(0, 3)) t.insert(t.size(), 8'($urandom));
      end
      return t;
   endfunction

   initial begin : stimulus
      int ph, phase_start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_signed_mode(1'b0);
      send_token(text_chars(""));
      send_token(text_chars("0x"));
      send_token(text_chars("0XfF"));
      send_token('{CHAR_PLUS, 8'hFF});
      send_token('{8'h37, CHAR_NUL, CHAR_LOWX});
      send_token('{CHAR_NUL});
      wait_quiet(SETTLE_CYCLES);
      // a write to an unmapped address must leave signed_mode alone
      csr_access(1'b1, UNUSED_ADDR, 32'hFFFF_FFFF);
      csr_access(1'b0, SIGNED_MODE_ADDR, 32'h0);
      set_signed_mode(1'b1);
      send_token(text_chars("-"));
      send_token(text_chars("-12"));
      // sign taken in signed mode, then the mode drops before the digits
      send_beat(CHAR_MINUS, 1'b0);
      wait_quiet(SETTLE_CYCLES);
      set_signed_mode(1'b0);
      send_token(text_chars("3"));

      for (ph = 0; ph < 8; ph++) begin
         wait_quiet(SETTLE_CYCLES);
         set_signed_mode(ph[0]);
         case (ph / 2)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
         endcase
         if (ph == 1) hold_armed = 1'b1;
         phase_start = beats_sent;
         while (beats_sent - phase_start < BEATS_PER_PHASE) send_token(make_token());
      end

      wait_quiet(SETTLE_CYCLES + 2);
      $display("sent %0d beats in %0d tokens, %0d results checked, %0d mismatches",
               beats_sent, tokens_sent, results_checked, mismatch_count);
      $display("both sign modes, decimal/hex/noise tokens, four flow-control mixes, one long hold");
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* ascii_integer_parser_unit.f */
rtl/aip_pkg.sv
rtl/aip_csr.sv
rtl/aip_parse.sv
rtl/ascii_integer_parser_unit.sv
tb/aip_result_checker.sv
tb/tb_top.sv
